### sv/bdpc_pkg.sv
// Package for the button debounce and press classifier.
// Widths, register indexes, reset values and state and event codes.
// No dependencies.
`default_nettype none

package bdpc_pkg;

	localparam int MAX_BUTTONS     = 5;
	localparam int NUM_BUTTONS_DEF = 5;

	localparam int EVENTS_W   = 10;
	localparam int NOTICES_W  = 10;
	localparam int MASK_W     = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 60;

	localparam int PERIOD_W = 8;
	localparam int DEB_W    = 8;
	localparam int THR_W    = 12;
	localparam int HELD_W   = 13;

	localparam int PERIOD_TBL_W = PERIOD_W * MAX_BUTTONS;
	localparam int DEB_TBL_W    = DEB_W * MAX_BUTTONS;
	localparam int THR_TBL_W    = THR_W * MAX_BUTTONS;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEB    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR    = 2'd2;

	localparam logic [PERIOD_TBL_W-1:0] PERIOD_RST = 40'h01_0101_0101;
	localparam logic [DEB_TBL_W-1:0]    DEB_RST    = 40'h03_0303_0303;
	localparam logic [THR_TBL_W-1:0]    THR_RST    = 60'h064_064_064_064_064;

	// Per-button debounce states
	localparam logic [1:0] ST_REL = 2'd0;
	localparam logic [1:0] ST_PCF = 2'd1;
	localparam logic [1:0] ST_PSH = 2'd2;
	localparam logic [1:0] ST_RCF = 2'd3;

	// Raw event codes (the fourth code counts as no event)
	localparam logic [1:0] EV_RELEASED = 2'd1;
	localparam logic [1:0] EV_PUSHED   = 2'd2;

	// Notice codes
	localparam logic [1:0] NT_NONE  = 2'd0;
	localparam logic [1:0] NT_SHORT = 2'd1;
	localparam logic [1:0] NT_LONG  = 2'd2;

	localparam logic [DEB_W-1:0]  DEB_MAX  = '1;
	localparam logic [HELD_W-1:0] HELD_MAX = '1;

endpackage

`default_nettype wire

### sv/button_debounce_press_classifier.sv
// Button debounce and short/long press classifier, top level.
// Depends on bdpc_pkg.
`default_nettype none

// One request on the input channel is one tick carrying a raw event for every
// button; each tick gives exactly one result request with a notice per button
// and a mask of the buttons that were stepped. A new tick is taken every clock
// cycle while out_ready stays high: the tick is held in an input register, all
// buttons are updated side by side in one pass of logic, and the result lands
// in an output register, which drives out_valid; throughput is one tick per
// cycle while out_ready stays high. A stalled result blocks at most one
// further tick in the input register. Each button has its own divider counter;
// a period of 0 switches the button off. Configuration writes take effect at
// the edge on which they are accepted and should be made only while the block
// holds no tick in flight; cfg_ready is always high and writes to an unused
// index are dropped.
module button_debounce_press_classifier #(
	parameter int NUM_BUTTONS = bdpc_pkg::NUM_BUTTONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// tick channel
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [bdpc_pkg::EVENTS_W-1:0]   button_events,
	// result channel
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [bdpc_pkg::NOTICES_W-1:0]       press_notices,
	output logic [bdpc_pkg::MASK_W-1:0]          stepped_mask,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [bdpc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bdpc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bdpc_pkg::*;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [PERIOD_TBL_W-1:0] period_q;
	logic [DEB_TBL_W-1:0]    deb_q;
	logic [THR_TBL_W-1:0]    thr_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RST;
			deb_q    <= DEB_RST;
			thr_q    <= THR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PERIOD: period_q <= cfg_data[PERIOD_TBL_W-1:0];
				REG_DEB:    deb_q    <= cfg_data[DEB_TBL_W-1:0];
				REG_THR:    thr_q    <= cfg_data[THR_TBL_W-1:0];
				default:    ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Handshake: input register then result register
	// ---------------------------------------------------------------
	logic                valid_s1;
	logic [EVENTS_W-1:0] events_s1;
	logic                out_valid_q;
	logic                advance;   // result register can take the tick in stage 1
	logic                go;        // tick in stage 1 is processed this cycle

	assign advance  = !out_valid_q || out_ready;
	assign go       = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			events_s1 <= button_events;
		end
	end

	// ---------------------------------------------------------------
	// Per-button state
	// ---------------------------------------------------------------
	logic [PERIOD_W-1:0] phase_q [NUM_BUTTONS];
	logic [1:0]          state_q [NUM_BUTTONS];
	logic [DEB_W-1:0]    deb_cnt_q [NUM_BUTTONS];
	logic [HELD_W-1:0]   held_q [NUM_BUTTONS];

	logic [PERIOD_W-1:0] phase_d [NUM_BUTTONS];
	logic [1:0]          state_d [NUM_BUTTONS];
	logic [DEB_W-1:0]    deb_cnt_d [NUM_BUTTONS];
	logic [HELD_W-1:0]   held_d [NUM_BUTTONS];
	logic [NOTICES_W-1:0] notices_d;
	logic [MASK_W-1:0]    stepped_d;

	// All buttons in parallel. For a stepped button the event transition runs
	// first, then the behaviour of whatever state it lands in runs once.
	always_comb begin
		logic [PERIOD_W-1:0] per;
		logic [DEB_W-1:0]    deb_cfg;
		logic [THR_W-1:0]    thr;
		logic [1:0]          ev;
		logic [1:0]          s;
		logic [DEB_W-1:0]    d;
		logic [HELD_W-1:0]   h;
		logic [1:0]          note;

		notices_d = '0;
		stepped_d = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			per     = period_q[PERIOD_W*b +: PERIOD_W];
			deb_cfg = deb_q[DEB_W*b +: DEB_W];
			thr     = thr_q[THR_W*b +: THR_W];
			ev      = events_s1[2*b +: 2];
			s       = state_q[b];
			d       = deb_cnt_q[b];
			h       = held_q[b];
			note    = NT_NONE;

			// divider
			if (per == '0) begin
				phase_d[b] = '0;
			end else if ({1'b0, phase_q[b]} + 9'd1 >= {1'b0, per}) begin
				phase_d[b]   = '0;
				stepped_d[b] = 1'b1;
			end else begin
				phase_d[b] = phase_q[b] + 8'd1;
			end

			if (stepped_d[b]) begin
				// event transitions
				unique case (s)
					ST_REL: begin
						if (ev == EV_PUSHED) begin
							s = ST_PCF;
							d = '0;
						end
					end
					ST_PCF: begin
						if (ev == EV_RELEASED) begin
							s = ST_REL;
							d = '0;
							if (h != '0 && h <= {1'b0, thr}) note = NT_SHORT;
							h = '0;
						end
					end
					ST_PSH: begin
						if (ev == EV_RELEASED) begin
							s = ST_RCF;
							d = '0;
						end
					end
					ST_RCF: begin
						// a push here drops straight back to released
						if (ev == EV_PUSHED) begin
							s = ST_REL;
							d = '0;
							if (h != '0 && h <= {1'b0, thr}) note = NT_SHORT;
							h = '0;
						end
					end
					default: ;
				endcase

				// state behaviour
				unique case (s)
					ST_PCF, ST_RCF: begin
						if (d != DEB_MAX) d = d + 8'd1;
						if (d >= deb_cfg) begin
							d = '0;
							if (s == ST_PCF) begin
								s = ST_PSH;
								h = '0;
							end else begin
								s = ST_REL;
								if (h != '0 && h <= {1'b0, thr}) note = NT_SHORT;
								h = '0;
							end
						end
					end
					ST_PSH: begin
						if (h != HELD_MAX) h = h + 13'd1;
						if (h >= {1'b0, thr}) note = NT_LONG;
					end
					default: ;
				endcase
			end

			state_d[b]   = s;
			deb_cnt_d[b] = d;
			held_d[b]    = h;
			notices_d[2*b +: 2] = note;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				phase_q[b]   <= '0;
				state_q[b]   <= ST_REL;
				deb_cnt_q[b] <= '0;
				held_q[b]    <= '0;
			end
		end else if (go) begin
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				phase_q[b]   <= phase_d[b];
				state_q[b]   <= state_d[b];
				deb_cnt_q[b] <= deb_cnt_d[b];
				held_q[b]    <= held_d[b];
			end
		end
	end

	// ---------------------------------------------------------------
	// Result register
	// ---------------------------------------------------------------
	logic [NOTICES_W-1:0] notices_q;
	logic [MASK_W-1:0]    stepped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			notices_q <= notices_d;
			stepped_q <= stepped_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign press_notices = notices_q;
	assign stepped_mask  = stepped_q;

endmodule

`default_nettype wire

### sv/bdpc_checker.sv
// Port-level checks for the button debounce and press classifier.
// Depends on bdpc_pkg; bound to button_debounce_press_classifier below.
`default_nettype none

module bdpc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic [bdpc_pkg::EVENTS_W-1:0]  button_events,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic [bdpc_pkg::NOTICES_W-1:0] press_notices,
	input wire logic [bdpc_pkg::MASK_W-1:0]    stepped_mask
);
	import bdpc_pkg::*;

	logic [MASK_W-1:0] notice_nz;   // button has some notice
	logic [MASK_W-1:0] notice_bad;  // unused notice code

	always_comb begin
		for (int b = 0; b < MAX_BUTTONS; b++) begin
			notice_nz[b]  = press_notices[2*b +: 2] != NT_NONE;
			notice_bad[b] = press_notices[2*b +: 2] > NT_LONG;
		end
	end

	// a waiting tick holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(button_events))
		else $error("tick changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(press_notices)
			&& $stable(stepped_mask))
		else $error("result changed while stalled");

	// only a stepped button may report
	a_notice_stepped: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (notice_nz & ~stepped_mask) == '0)
		else $error("notice on a button that was not stepped");

	a_notice_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> notice_bad == '0)
		else $error("unused notice code");

	// a fresh result follows a tick accepted into the input register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("result without an accepted tick");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.button_events (button_events),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.press_notices (press_notices),
	.stepped_mask  (stepped_mask)
);

`default_nettype wire

### test/tb_button_debounce_press_classifier.sv
// Self-checking testbench for button_debounce_press_classifier.
// Predicts every tick result with its own per-button debounce model.
// Depends on bdpc_pkg and the block's top level.

module tb_button_debounce_press_classifier;

	import bdpc_pkg::*;

	localparam int NUM_BUTTONS = NUM_BUTTONS_DEF;

	// Event codes the package leaves unnamed: nothing, and the fourth code
	// which the block must treat as nothing.
	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_IGNORED = 2'd3;

	// Index with no register behind it; writes there must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// The same event or notice on every button.
	localparam logic [EVENTS_W-1:0]  EVENTS_NONE    = {MAX_BUTTONS{EV_NONE}};
	localparam logic [EVENTS_W-1:0]  EVENTS_PUSH    = {MAX_BUTTONS{EV_PUSHED}};
	localparam logic [EVENTS_W-1:0]  EVENTS_RELEASE = {MAX_BUTTONS{EV_RELEASED}};
	localparam logic [EVENTS_W-1:0]  EVENTS_IGNORED = {MAX_BUTTONS{EV_IGNORED}};
	localparam logic [NOTICES_W-1:0] NOTICES_NONE   = {MAX_BUTTONS{NT_NONE}};
	localparam logic [NOTICES_W-1:0] NOTICES_SHORT  = {MAX_BUTTONS{NT_SHORT}};
	localparam logic [MASK_W-1:0]    MASK_ALL       = {MASK_W{1'b1}};

	// Watchdog: far beyond the slowest legal run.
	localparam int RUN_LIMIT = 20_000_000;

	typedef struct packed {
		logic [NOTICES_W-1:0] notices;
		logic [MASK_W-1:0]    mask;
	} tick_result_t;

	// One directed tick. Where typed is set the expected result is the one
	// written in the row; otherwise the predictor supplies it.
	typedef struct packed {
		logic [EVENTS_W-1:0]  events;
		logic                 typed;
		logic [NOTICES_W-1:0] notices;
		logic [MASK_W-1:0]    mask;
	} tick_row_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idling_t;

	// Directed ticks, run with the reset settings: every button stepped on
	// every tick, three confirm steps, long-press threshold of 100.
	localparam int DIRECTED_LEN = 24;
	localparam tick_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
		'{EVENTS_NONE,    1'b1, NOTICES_NONE,  MASK_ALL},  // quiet after reset
		'{EVENTS_IGNORED, 1'b1, NOTICES_NONE,  MASK_ALL},  // fourth code: no event
		'{EVENTS_PUSH,    1'b1, NOTICES_NONE,  MASK_ALL},  // into press-confirm
		'{EVENTS_RELEASE, 1'b1, NOTICES_NONE,  MASK_ALL},  // bounce: back, nothing held
		'{EVENTS_PUSH,    1'b1, NOTICES_NONE,  MASK_ALL},
		'{EVENTS_NONE,    1'b1, NOTICES_NONE,  MASK_ALL},
		'{EVENTS_NONE,    1'b1, NOTICES_NONE,  MASK_ALL},  // third step: pressed
		'{EVENTS_NONE,    1'b1, NOTICES_NONE,  MASK_ALL},  // held for one step
		'{EVENTS_RELEASE, 1'b1, NOTICES_NONE,  MASK_ALL},  // into release-confirm
		'{EVENTS_PUSH,    1'b1, NOTICES_SHORT, MASK_ALL},  // push there: released, short
		'{EVENTS_PUSH,    1'b0, NOTICES_NONE,  '0},
		'{EVENTS_NONE,    1'b0, NOTICES_NONE,  '0},
		'{EVENTS_NONE,    1'b0, NOTICES_NONE,  '0},
		'{EVENTS_NONE,    1'b0, NOTICES_NONE,  '0},
		'{EVENTS_NONE,    1'b0, NOTICES_NONE,  '0},
		'{EVENTS_RELEASE, 1'b0, NOTICES_NONE,  '0},
		'{EVENTS_NONE,    1'b0, NOTICES_NONE,  '0},
		'{EVENTS_NONE,    1'b0, NOTICES_NONE,  '0},  // confirmed release
		'{{EV_PUSHED, EV_NONE, EV_RELEASED, EV_IGNORED, EV_PUSHED}, 1'b0, NOTICES_NONE, '0},
		'{{EV_IGNORED, EV_PUSHED, EV_PUSHED, EV_RELEASED, EV_NONE}, 1'b0, NOTICES_NONE, '0},
		'{EVENTS_NONE,    1'b0, NOTICES_NONE,  '0},
		'{EVENTS_NONE,    1'b0, NOTICES_NONE,  '0},
		'{{EV_RELEASED, EV_RELEASED, EV_PUSHED, EV_PUSHED, EV_IGNORED}, 1'b0, NOTICES_NONE, '0},
		'{EVENTS_IGNORED, 1'b0, NOTICES_NONE,  '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [EVENTS_W-1:0]   button_events = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [NOTICES_W-1:0]  press_notices;
	logic [MASK_W-1:0]     stepped_mask;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor copy of the settings and of each button's state
	logic [PERIOD_TBL_W-1:0] period_reg;
	logic [DEB_TBL_W-1:0]    debounce_reg;
	logic [THR_TBL_W-1:0]    threshold_reg;
	logic [PERIOD_W-1:0]     divider [MAX_BUTTONS];
	logic [1:0]              btn_state [MAX_BUTTONS];
	logic [DEB_W-1:0]        confirm_steps [MAX_BUTTONS];
	logic [HELD_W-1:0]       hold_steps [MAX_BUTTONS];

	tick_result_t predicted_ticks [$];

	int fail_count = 0;
	int src_idle_pct = 0;
	int snk_stall_pct = 0;

	button_debounce_press_classifier #(
		.NUM_BUTTONS(NUM_BUTTONS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.button_events(button_events),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.press_notices(press_notices),
		.stepped_mask(stepped_mask),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#RUN_LIMIT;
		$display("FAIL button_debounce_press_classifier");
		$finish;
	end

	// Moves a button to a new state with its exit and entry actions. Leaving
	// or entering a confirm state clears the confirm count; entering released
	// gives a short notice for a hold at or under the threshold.
	function automatic void move_to(input int b, input logic [1:0] nxt,
			inout logic [1:0] note);
		logic [THR_W-1:0] thr;
		thr = threshold_reg[THR_W*b +: THR_W];
		if (btn_state[b] == ST_PCF || btn_state[b] == ST_RCF)
			confirm_steps[b] = '0;
		btn_state[b] = nxt;
		case (nxt)
			ST_REL: begin
				if (hold_steps[b] != '0 && hold_steps[b] <= thr)
					note = NT_SHORT;
				hold_steps[b] = '0;
			end
			ST_PSH: hold_steps[b] = '0;
			default: confirm_steps[b] = '0;
		endcase
	endfunction

	// Advances every button by one tick and returns the result it owes.
	function automatic tick_result_t classify_tick(input logic [EVENTS_W-1:0] events);
		tick_result_t res;
		logic [PERIOD_W-1:0] per;
		logic [THR_W-1:0] thr;
		logic [1:0] ev;
		logic [1:0] cur;
		logic [1:0] note;
		res = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			per = period_reg[PERIOD_W*b +: PERIOD_W];
			thr = threshold_reg[THR_W*b +: THR_W];
			note = NT_NONE;
			if (per == '0) begin
				// switched off: divider parked, state frozen
				divider[b] = '0;
			end else if (divider[b] + 9'd1 >= per) begin
				// also catches a period lowered under a running divider
				divider[b] = '0;
				res.mask[b] = 1'b1;
				ev = events[2*b +: 2];
				cur = btn_state[b];
				if (cur == ST_REL && ev == EV_PUSHED)
					move_to(b, ST_PCF, note);
				else if (cur == ST_PCF && ev == EV_RELEASED)
					move_to(b, ST_REL, note);
				else if (cur == ST_PSH && ev == EV_RELEASED)
					move_to(b, ST_RCF, note);
				else if (cur == ST_RCF && ev == EV_PUSHED)
					move_to(b, ST_REL, note);
				// then the current state's work runs once
				cur = btn_state[b];
				if (cur == ST_PCF || cur == ST_RCF) begin
					if (confirm_steps[b] != DEB_MAX)
						confirm_steps[b]++;
					if (confirm_steps[b] >= debounce_reg[DEB_W*b +: DEB_W])
						move_to(b, (cur == ST_PCF) ? ST_PSH : ST_REL, note);
				end else if (cur == ST_PSH) begin
					if (hold_steps[b] != HELD_MAX)
						hold_steps[b]++;
					if (hold_steps[b] >= thr)
						note = NT_LONG;
				end
				res.notices[2*b +: 2] = note;
			end else begin
				divider[b]++;
			end
		end
		return res;
	endfunction

	task automatic set_idling(input idling_t mode);
		case (mode)
			IDLE_NONE: begin
				src_idle_pct = 0;
				snk_stall_pct = 0;
			end
			IDLE_SENDER: begin
				src_idle_pct = 80;
				snk_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				src_idle_pct = 0;
				snk_stall_pct = 80;
			end
			default: begin
				src_idle_pct = 6;
				snk_stall_pct = 6;
			end
		endcase
	endtask

	// Offers one tick request after a random gap and records the result it
	// owes once accepted. Returns at the accepting rising edge.
	task automatic send_tick(input logic [EVENTS_W-1:0] events, input logic typed,
			input tick_result_t typed_result);
		int gap;
		tick_result_t predicted;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < src_idle_pct)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		button_events <= events;
		do @(posedge clk); while (!in_ready);
		predicted = classify_tick(events);
		predicted_ticks.push_back(typed ? typed_result : predicted);
	endtask

	// Stops offering ticks and waits until every owed result has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (predicted_ticks.size() != 0)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_PERIOD: period_reg = data[PERIOD_TBL_W-1:0];
			REG_DEB:    debounce_reg = data[DEB_TBL_W-1:0];
			REG_THR:    threshold_reg = data[THR_TBL_W-1:0];
			default: ;
		endcase
	endtask

	// Writes all three tables; spare upper data bits carry junk, which the
	// block must ignore.
	task automatic configure(input logic [PERIOD_TBL_W-1:0] per,
			input logic [DEB_TBL_W-1:0] deb, input logic [THR_TBL_W-1:0] thr);
		logic [63:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_PERIOD, {junk[CFG_DATA_W-1:PERIOD_TBL_W], per});
		write_reg(REG_DEB, {~junk[CFG_DATA_W-1:DEB_TBL_W], deb});
		write_reg(REG_THR, thr);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Random ticks; evt_pct is the chance of a raw event per button per tick.
	// Low rates let debouncing complete so most presses run their full course.
	// Halfway through, the sender holds off until the block has drained.
	task automatic run_random(input int count, input int evt_pct);
		logic [EVENTS_W-1:0] events;
		for (int k = 0; k < count; k++) begin
			if (k == count / 2)
				drain_results();
			for (int b = 0; b < MAX_BUTTONS; b++)
				events[2*b +: 2] = ($urandom_range(99) < evt_pct) ?
					2'($urandom_range(3, 1)) : EV_NONE;
			send_tick(events, 1'b0, '0);
		end
	endtask

	// Receiver side: ready redrawn every falling edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(99) >= snk_stall_pct);

	// Result checker: each accepted result against the oldest owed one.
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (predicted_ticks.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: notices %h mask %h",
						press_notices, stepped_mask);
			end else begin
				want = predicted_ticks.pop_front();
				if (press_notices !== want.notices || stepped_mask !== want.mask) begin
					fail_count++;
					if (fail_count <= 10)
						$display("result mismatch: notices exp %h got %h, mask exp %h got %h",
							want.notices, press_notices, want.mask, stepped_mask);
				end
			end
		end
	end

	initial begin
		logic [PERIOD_TBL_W-1:0] per_tbl;
		logic [DEB_TBL_W-1:0]    deb_tbl;
		logic [THR_TBL_W-1:0]    thr_tbl;

		period_reg = PERIOD_RST;
		debounce_reg = DEB_RST;
		threshold_reg = THR_RST;
		for (int b = 0; b < MAX_BUTTONS; b++) begin
			divider[b] = '0;
			btn_state[b] = ST_REL;
			confirm_steps[b] = '0;
			hold_steps[b] = '0;
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: directed table, then a short random run, no idling
		set_idling(IDLE_NONE);
		for (int i = 0; i < DIRECTED_LEN; i++)
			send_tick(DIRECTED_ROWS[i].events, DIRECTED_ROWS[i].typed,
				{DIRECTED_ROWS[i].notices, DIRECTED_ROWS[i].mask});
		run_random(40, 30);

		// Low extremes: commit on the first confirm step, threshold 0 so every
		// held step is long and no short ever comes. The unused index first.
		drain_results();
		write_reg(REG_UNUSED, CFG_DATA_W'({$urandom, $urandom}));
		configure({MAX_BUTTONS{8'h01}}, '0, '0);
		set_idling(IDLE_SENDER);
		run_random(60, 30);

		// Slow dividers, one button off; one divider is left high for the next
		// phase to cut the period beneath it.
		drain_results();
		configure({8'h30, 8'h02, 8'hFF, 8'h01, 8'h00},
			{8'd1, 8'd2, 8'd0, 8'd3, 8'd1},
			{12'd2, 12'd1, 12'd0, 12'd3, 12'd5});
		set_idling(IDLE_RECEIVER);
		run_random(150, 20);

		// High extremes on one long hold: 255 confirm steps on two buttons,
		// threshold 4095 on most, so the quick buttons with that threshold release with a short.
		drain_results();
		configure({MAX_BUTTONS{8'h01}}, {8'hFF, 8'd2, 8'd2, 8'hFF, 8'd2},
			{12'hFFF, 12'hFFF, 12'd0, 12'd1, 12'hFFF});
		set_idling(IDLE_NONE);
		send_tick(EVENTS_PUSH, 1'b0, '0);
		repeat (260)
			send_tick(EVENTS_NONE, 1'b0, '0);
		send_tick(EVENTS_RELEASE, 1'b0, '0);
		repeat (30)
			send_tick(EVENTS_NONE, 1'b0, '0);

		// Random settings, mostly small so presses finish and cross their
		// thresholds, now and then full-width values.
		for (int p = 0; p < 5; p++) begin
			drain_results();
			for (int b = 0; b < MAX_BUTTONS; b++) begin
				per_tbl[PERIOD_W*b +: PERIOD_W] = ($urandom_range(9) == 0) ? 8'h00 :
					($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(3, 1));
				deb_tbl[DEB_W*b +: DEB_W] = ($urandom_range(5) == 0) ?
					8'($urandom) : 8'($urandom_range(4));
				thr_tbl[THR_W*b +: THR_W] = ($urandom_range(5) == 0) ?
					12'($urandom) : 12'($urandom_range(12));
			end
			configure(per_tbl, deb_tbl, thr_tbl);
			case (p)
				0: set_idling(IDLE_SENDER);
				1: set_idling(IDLE_RECEIVER);
				2: set_idling(IDLE_BOTH);
				3: set_idling(IDLE_NONE);
				default: set_idling(IDLE_BOTH);
			endcase
			run_random(40, (p % 3 == 0) ? 10 : (p % 3 == 1) ? 30 : 60);
		end

		// Everything back, then a wait to catch any stray result
		drain_results();
		repeat (6) @(posedge clk);
		if (fail_count == 0)
			$display("PASS button_debounce_press_classifier");
		else
			$display("FAIL button_debounce_press_classifier");
		$finish;
	end

endmodule
